[rtl/rta_pkg.sv]
// ----------------------------------------------------------------------------
// rta_pkg
// Shared types and constants for the rational arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rta_pkg;

  localparam int unsigned FieldWidth    = 64;
  localparam int unsigned DenWidth      = 63;
  localparam int unsigned DefValueWidth = 64;

  typedef enum logic [1:0] {
    ACT_NORM = 2'd0,
    ACT_ADD  = 2'd1,
    ACT_CMP  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  // order codes, two's complement
  localparam logic [1:0] OrdLt = 2'b11;
  localparam logic [1:0] OrdEq = 2'b00;
  localparam logic [1:0] OrdGt = 2'b01;

  // datapath micro-operations
  typedef enum logic [3:0] {
    CMD_GCD_A,
    CMD_DIVN_A,
    CMD_DIVD_A,
    CMD_GCD_B,
    CMD_DIVN_B,
    CMD_DIVD_B,
    CMD_MUL_P,
    CMD_MUL_Q,
    CMD_MUL_D,
    CMD_SUM,
    CMD_GCD_R,
    CMD_DIVN_R,
    CMD_DIVD_R,
    CMD_RESULT
  } cmd_e;

  typedef struct packed {
    logic load;
    logic start;
    cmd_e op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic       eng_done;
    logic       out_busy;
    logic       a_inv;
    logic       b_inv;
    logic       fit;
    logic [1:0] action;
  } dp_stat_t;

endpackage

`default_nettype wire

[rtl/rta_in_if.sv]
// ----------------------------------------------------------------------------
// rta_in_if
// Request channel: action code and two rational operands.
// ----------------------------------------------------------------------------
`default_nettype none

interface rta_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [1:0]                             action;
  logic signed [rta_pkg::FieldWidth-1:0]  a_num;
  logic signed [rta_pkg::FieldWidth-1:0]  a_den;
  logic signed [rta_pkg::FieldWidth-1:0]  b_num;
  logic signed [rta_pkg::FieldWidth-1:0]  b_den;

  modport source (output valid, action, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, action, a_num, a_den, b_num, b_den, output ready);
endinterface

`default_nettype wire

[rtl/rta_out_if.sv]
// ----------------------------------------------------------------------------
// rta_out_if
// Response channel: status, reduced rational and compare order.
// ----------------------------------------------------------------------------
`default_nettype none

interface rta_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [1:0]                            status;
  logic signed [rta_pkg::FieldWidth-1:0] res_num;
  logic [rta_pkg::DenWidth-1:0]          res_den;
  logic signed [1:0]                     order;

  modport source (output valid, status, res_num, res_den, order, input ready);
  modport sink   (input valid, status, res_num, res_den, order, output ready);
endinterface

`default_nettype wire

[rtl/rational_time_arith_unit.sv]
// ----------------------------------------------------------------------------
// rational_time_arith_unit
// Normalize, add and compare of signed rationals num/den.
// ----------------------------------------------------------------------------
// One transaction in, one transaction out. Normalize makes the denominator
// positive and reduces by the gcd; add reduces both operands, forms the exact
// cross-product sum, range checks it and, if it fits, reduces it; compare
// gives the sign of a - b. Parts are VALUE_WIDTH-bit two's complement (low
// bits of the 64-bit fields, sign-extended). All arithmetic runs on one
// shared iterative engine that does one step per cycle: a binary gcd (at
// most about 2*W steps), a restoring divide (W steps) or a shift-add
// multiply (W steps), W being VALUE_WIDTH. Normalize uses one gcd and two
// divides, add up to three gcds, six divides and three multiplies, and
// compare two multiplies; invalid operands and undefined actions go straight
// to the result. The engine is the bottleneck, so one transaction is in
// flight at a time; the result register lets the next request be taken
// while the last result still waits for the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module rational_time_arith_unit #(
  parameter int unsigned VALUE_WIDTH = rta_pkg::DefValueWidth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rta_in_if.sink     in_i,
  rta_out_if.source  out_o
);
  import rta_pkg::*;

  ctrl_cmd_t cmd;   // sequencer -> datapath
  dp_stat_t  stat;  // datapath -> sequencer

  // sequencer: state machine that steps through micro-operations
  rta_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // datapath: operands, shared engine, result register
  rta_dp #(
    .W (VALUE_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .action_i    (in_i.action),
    .a_num_i     (in_i.a_num),
    .a_den_i     (in_i.a_den),
    .b_num_i     (in_i.b_num),
    .b_den_i     (in_i.b_den),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .status_o    (out_o.status),
    .res_num_o   (out_o.res_num),
    .res_den_o   (out_o.res_den),
    .order_o     (out_o.order)
  );

endmodule

`default_nettype wire

[rtl/rta_ctrl.sv]
// ----------------------------------------------------------------------------
// rta_ctrl
// Sequencer: walks each transaction through the datapath micro-operations.
// ----------------------------------------------------------------------------
`default_nettype none

module rta_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rta_pkg::dp_stat_t   stat_i,
  output rta_pkg::ctrl_cmd_t  cmd_o
);
  import rta_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_STEP,
    S_WAIT,
    S_SUM,
    S_SUMW,
    S_CHECK,
    S_RESULT
  } state_e;

  state_e state_q;
  cmd_e   step_q;
  cmd_e   op_q;
  logic   start_q;

  cmd_e   nxt_op;
  state_e nxt_state;

  // successor of the finished engine step
  always_comb begin
    nxt_op    = step_q;
    nxt_state = S_STEP;
    case (step_q)
      CMD_GCD_A:  nxt_op = CMD_DIVN_A;
      CMD_DIVN_A: nxt_op = CMD_DIVD_A;
      CMD_DIVD_A: begin
        if (stat_i.action == ACT_ADD) nxt_op = CMD_GCD_B;
        else nxt_state = S_RESULT;
      end
      CMD_GCD_B:  nxt_op = CMD_DIVN_B;
      CMD_DIVN_B: nxt_op = CMD_DIVD_B;
      CMD_DIVD_B: nxt_op = CMD_MUL_P;
      CMD_MUL_P:  nxt_op = CMD_MUL_Q;
      CMD_MUL_Q: begin
        if (stat_i.action == ACT_ADD) nxt_op = CMD_MUL_D;
        else nxt_state = S_RESULT;
      end
      CMD_MUL_D:  nxt_state = S_SUM;
      CMD_GCD_R:  nxt_op = CMD_DIVN_R;
      CMD_DIVN_R: nxt_op = CMD_DIVD_R;
      default:    nxt_state = S_RESULT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= CMD_GCD_A;
      op_q    <= CMD_RESULT;
      start_q <= 1'b0;
    end else begin
      start_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_DECIDE;
        end
        S_DECIDE: begin
          case (stat_i.action)
            ACT_NORM: begin
              if (stat_i.a_inv) state_q <= S_RESULT;
              else begin
                step_q  <= CMD_GCD_A;
                state_q <= S_STEP;
              end
            end
            ACT_ADD: begin
              if (stat_i.a_inv || stat_i.b_inv) state_q <= S_RESULT;
              else begin
                step_q  <= CMD_GCD_A;
                state_q <= S_STEP;
              end
            end
            ACT_CMP: begin
              // order survives without reduction: go straight to products
              if (stat_i.a_inv || stat_i.b_inv) state_q <= S_RESULT;
              else begin
                step_q  <= CMD_MUL_P;
                state_q <= S_STEP;
              end
            end
            default: state_q <= S_RESULT;
          endcase
        end
        S_STEP: begin
          start_q <= 1'b1;
          op_q    <= step_q;
          state_q <= S_WAIT;
        end
        S_WAIT: begin
          if (stat_i.eng_done) begin
            step_q  <= nxt_op;
            state_q <= nxt_state;
          end
        end
        S_SUM: begin
          start_q <= 1'b1;
          op_q    <= CMD_SUM;
          state_q <= S_SUMW;
        end
        S_SUMW: state_q <= S_CHECK;
        S_CHECK: begin
          if (stat_i.fit) begin
            step_q  <= CMD_GCD_R;
            state_q <= S_STEP;
          end else begin
            state_q <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (!stat_i.out_busy) begin
            start_q <= 1'b1;
            op_q    <= CMD_RESULT;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign cmd_o.load  = in_valid_i && (state_q == S_IDLE);
  assign cmd_o.start = start_q;
  assign cmd_o.op    = op_q;

endmodule

`default_nettype wire

[rtl/rta_dp.sv]
// ----------------------------------------------------------------------------
// rta_dp
// Operand registers, shared iterative gcd/divide/multiply engine, sum check,
// compare and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rta_dp #(
  parameter int unsigned W = rta_pkg::DefValueWidth
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  rta_pkg::ctrl_cmd_t                     cmd_i,
  output rta_pkg::dp_stat_t                      stat_o,
  input  logic [1:0]                             action_i,
  input  logic signed [rta_pkg::FieldWidth-1:0]  a_num_i,
  input  logic signed [rta_pkg::FieldWidth-1:0]  a_den_i,
  input  logic signed [rta_pkg::FieldWidth-1:0]  b_num_i,
  input  logic signed [rta_pkg::FieldWidth-1:0]  b_den_i,
  input  logic                                   out_ready_i,
  output logic                                   out_valid_o,
  output logic [1:0]                             status_o,
  output logic signed [rta_pkg::FieldWidth-1:0]  res_num_o,
  output logic [rta_pkg::DenWidth-1:0]           res_den_o,
  output logic signed [1:0]                      order_o
);
  import rta_pkg::*;

  localparam int unsigned W2 = 2 * W;
  localparam int unsigned CW = $clog2(W);
  localparam logic [W-1:0]  MinMag  = {1'b1, {(W-1){1'b0}}};
  localparam logic [W2-1:0] MinWide = W2'(MinMag);
  localparam logic [W2-1:0] MaxWide = MinWide - W2'(1);

  typedef enum logic [1:0] {EOP_GCD, EOP_DIV, EOP_MUL} eop_e;

  function automatic logic [W-1:0] mag_of(input logic [W-1:0] x);
    mag_of = x[W-1] ? (~x + 1'b1) : x;
  endfunction

  // ---- operand capture ----
  logic [W-1:0] ax_n, ax_d, bx_n, bx_d;
  logic [W-1:0] a_nm, a_dm, b_nm, b_dm;
  logic         a_inv_d, b_inv_d, a_neg_d, b_neg_d;

  assign ax_n = a_num_i[W-1:0];
  assign ax_d = a_den_i[W-1:0];
  assign bx_n = b_num_i[W-1:0];
  assign bx_d = b_den_i[W-1:0];
  assign a_nm = mag_of(ax_n);
  assign a_dm = mag_of(ax_d);
  assign b_nm = mag_of(bx_n);
  assign b_dm = mag_of(bx_d);

  // negative denominator flips signs; most negative part can not flip;
  // a zero numerator with a nonzero denominator always gives 0/1
  assign a_inv_d = (a_dm == '0) ||
                   ((a_nm != '0) && ax_d[W-1] &&
                    ((a_dm == MinMag) || (ax_n[W-1] && (a_nm == MinMag))));
  assign b_inv_d = (b_dm == '0) ||
                   ((b_nm != '0) && bx_d[W-1] &&
                    ((b_dm == MinMag) || (bx_n[W-1] && (b_nm == MinMag))));
  assign a_neg_d = (ax_n[W-1] ^ ax_d[W-1]) && (a_nm != '0);
  assign b_neg_d = (bx_n[W-1] ^ bx_d[W-1]) && (b_nm != '0);

  logic [W-1:0]  an_q, ad_q, bn_q, bd_q, g_q;
  logic          a_neg_q, b_neg_q, a_inv_q, b_inv_q, fit_q;
  logic [1:0]    act_q;
  logic [W2-1:0] p_q, q_q, d_q, n_q;

  // ---- engine ----
  logic          ebusy_q, edone_q;
  eop_e          eop_q;
  cmd_e          etgt_q;
  logic [W-1:0]  eu_q, ev_q, eu_d, ev_d;
  logic [W2-1:0] eacc_q, eacc_d;
  logic [CW-1:0] ecnt_q, ecnt_d, ek_q, ek_d;
  logic          wb_en;
  logic [W2-1:0] wb_val;

  eop_e          eop_sel;
  logic [W-1:0]  u_sel, v_sel;
  logic          eng_start, sum_start, res_start;

  assign sum_start = cmd_i.start && (cmd_i.op == CMD_SUM);
  assign res_start = cmd_i.start && (cmd_i.op == CMD_RESULT);
  assign eng_start = cmd_i.start && !sum_start && !res_start;

  always_comb begin
    eop_sel = EOP_MUL;
    u_sel   = an_q;
    v_sel   = bd_q;
    case (cmd_i.op)
      CMD_GCD_A:  begin eop_sel = EOP_GCD; u_sel = an_q;         v_sel = ad_q;         end
      CMD_DIVN_A: begin eop_sel = EOP_DIV; u_sel = an_q;         v_sel = g_q;          end
      CMD_DIVD_A: begin eop_sel = EOP_DIV; u_sel = ad_q;         v_sel = g_q;          end
      CMD_GCD_B:  begin eop_sel = EOP_GCD; u_sel = bn_q;         v_sel = bd_q;         end
      CMD_DIVN_B: begin eop_sel = EOP_DIV; u_sel = bn_q;         v_sel = g_q;          end
      CMD_DIVD_B: begin eop_sel = EOP_DIV; u_sel = bd_q;         v_sel = g_q;          end
      CMD_MUL_P:  begin eop_sel = EOP_MUL; u_sel = an_q;         v_sel = bd_q;         end
      CMD_MUL_Q:  begin eop_sel = EOP_MUL; u_sel = bn_q;         v_sel = ad_q;         end
      CMD_MUL_D:  begin eop_sel = EOP_MUL; u_sel = ad_q;         v_sel = bd_q;         end
      CMD_GCD_R:  begin eop_sel = EOP_GCD; u_sel = n_q[W-1:0];   v_sel = d_q[W-1:0];   end
      CMD_DIVN_R: begin eop_sel = EOP_DIV; u_sel = n_q[W-1:0];   v_sel = g_q;          end
      CMD_DIVD_R: begin eop_sel = EOP_DIV; u_sel = d_q[W-1:0];   v_sel = g_q;          end
      default: ;
    endcase
  end

  logic [W:0]    r2, rsub;
  logic          ge;
  logic [W:0]    msum;
  logic [W2:0]   macc;
  logic [W-1:0]  dif_uv, dif_vu;

  assign r2     = {eacc_q[W-1:0], eu_q[W-1]};
  assign rsub   = r2 - {1'b0, ev_q};
  assign ge     = (r2 >= {1'b0, ev_q});
  assign msum   = {1'b0, eacc_q[W2-1:W]} + (ev_q[0] ? {1'b0, eu_q} : '0);
  assign macc   = {msum, eacc_q[W-1:0]};
  assign dif_uv = eu_q - ev_q;
  assign dif_vu = ev_q - eu_q;

  // one step per cycle: binary gcd, restoring divide, shift-add multiply
  always_comb begin
    eu_d   = eu_q;
    ev_d   = ev_q;
    eacc_d = eacc_q;
    ecnt_d = ecnt_q;
    ek_d   = ek_q;
    wb_en  = 1'b0;
    wb_val = '0;
    case (eop_q)
      EOP_GCD: begin
        if (eu_q == '0) begin
          wb_en  = 1'b1;
          wb_val = W2'(ev_q << ek_q);
        end else if (!eu_q[0] && !ev_q[0]) begin
          eu_d = eu_q >> 1;
          ev_d = ev_q >> 1;
          ek_d = ek_q + 1'b1;
        end else if (!eu_q[0]) begin
          eu_d = eu_q >> 1;
        end else if (!ev_q[0]) begin
          ev_d = ev_q >> 1;
        end else if (eu_q >= ev_q) begin
          eu_d = dif_uv >> 1;
        end else begin
          ev_d = dif_vu >> 1;
        end
      end
      EOP_DIV: begin
        eacc_d = W2'(ge ? rsub[W-1:0] : r2[W-1:0]);
        eu_d   = {eu_q[W-2:0], ge};
        ecnt_d = ecnt_q + 1'b1;
        if (ecnt_q == CW'(W - 1)) begin
          wb_en  = 1'b1;
          wb_val = W2'({eu_q[W-2:0], ge});
        end
      end
      EOP_MUL: begin
        eacc_d = macc[W2:1];
        ev_d   = ev_q >> 1;
        ecnt_d = ecnt_q + 1'b1;
        if (ecnt_q == CW'(W - 1)) begin
          wb_en  = 1'b1;
          wb_val = macc[W2:1];
        end
      end
      default: ;
    endcase
  end

  // ---- sum and range check ----
  logic          same_sgn, pge, sum_neg, sum_fit;
  logic [W2-1:0] sum_n;

  assign same_sgn = (a_neg_q == b_neg_q);
  assign pge      = (p_q >= q_q);
  assign sum_n    = same_sgn ? (p_q + q_q) : (pge ? (p_q - q_q) : (q_q - p_q));
  assign sum_neg  = (sum_n != '0) && ((same_sgn || pge) ? a_neg_q : b_neg_q);
  assign sum_fit  = (sum_n <= (sum_neg ? MinWide : MaxWide)) && (d_q <= MaxWide);

  // ---- result formatting ----
  logic signed [W-1:0]            num_w;
  logic [FieldWidth-1:0]          den_w;
  logic [1:0]                     ord;
  logic [1:0]                     st_d;
  logic signed [FieldWidth-1:0]   num_d;
  logic [DenWidth-1:0]            den_d;
  logic [1:0]                     ord_d;

  assign num_w = a_neg_q ? (~an_q + 1'b1) : an_q;
  assign den_w = FieldWidth'(ad_q);

  always_comb begin
    if ((p_q == '0) && (q_q == '0))  ord = OrdEq;
    else if (p_q == '0)              ord = b_neg_q ? OrdGt : OrdLt;
    else if (q_q == '0)              ord = a_neg_q ? OrdLt : OrdGt;
    else if (a_neg_q != b_neg_q)     ord = a_neg_q ? OrdLt : OrdGt;
    else if (p_q == q_q)             ord = OrdEq;
    else if ((p_q > q_q) ^ a_neg_q)  ord = OrdGt;
    else                             ord = OrdLt;
  end

  always_comb begin
    st_d  = ST_INVALID;
    num_d = '0;
    den_d = '0;
    ord_d = OrdEq;
    case (act_q)
      ACT_NORM: begin
        if (!a_inv_q) begin
          st_d  = ST_OK;
          num_d = FieldWidth'(num_w);
          den_d = den_w[DenWidth-1:0];
        end
      end
      ACT_ADD: begin
        if (a_inv_q || b_inv_q || !fit_q) begin
          st_d = ST_OVERFLOW;
        end else begin
          st_d  = ST_OK;
          num_d = FieldWidth'(num_w);
          den_d = den_w[DenWidth-1:0];
        end
      end
      ACT_CMP: begin
        if (!a_inv_q && !b_inv_q) begin
          st_d  = ST_OK;
          ord_d = ord;
        end
      end
      default: ;
    endcase
  end

  logic                          out_valid_q;
  logic [1:0]                    out_status_q;
  logic signed [FieldWidth-1:0]  out_num_q;
  logic [DenWidth-1:0]           out_den_q;
  logic [1:0]                    out_order_q;

  // ---- control registers ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ebusy_q     <= 1'b0;
      edone_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      edone_q <= ebusy_q && wb_en;
      if (eng_start) ebusy_q <= 1'b1;
      else if (ebusy_q && wb_en) ebusy_q <= 1'b0;
      if (res_start) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // ---- payload registers ----
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      an_q    <= a_nm;
      ad_q    <= a_dm;
      bn_q    <= b_nm;
      bd_q    <= b_dm;
      a_neg_q <= a_neg_d;
      b_neg_q <= b_neg_d;
      a_inv_q <= a_inv_d;
      b_inv_q <= b_inv_d;
      act_q   <= action_i;
      fit_q   <= 1'b0;
    end
    if (eng_start) begin
      eop_q  <= eop_sel;
      etgt_q <= cmd_i.op;
      eu_q   <= u_sel;
      ev_q   <= v_sel;
      eacc_q <= '0;
      ecnt_q <= '0;
      ek_q   <= '0;
    end else if (ebusy_q) begin
      eu_q   <= eu_d;
      ev_q   <= ev_d;
      eacc_q <= eacc_d;
      ecnt_q <= ecnt_d;
      ek_q   <= ek_d;
    end
    if (ebusy_q && wb_en) begin
      case (etgt_q)
        CMD_GCD_A, CMD_GCD_B, CMD_GCD_R: g_q <= wb_val[W-1:0];
        CMD_DIVN_A, CMD_DIVN_R:          an_q <= wb_val[W-1:0];
        CMD_DIVD_A, CMD_DIVD_R:          ad_q <= wb_val[W-1:0];
        CMD_DIVN_B:                      bn_q <= wb_val[W-1:0];
        CMD_DIVD_B:                      bd_q <= wb_val[W-1:0];
        CMD_MUL_P:                       p_q  <= wb_val;
        CMD_MUL_Q:                       q_q  <= wb_val;
        CMD_MUL_D:                       d_q  <= wb_val;
        default: ;
      endcase
    end
    if (sum_start) begin
      n_q     <= sum_n;
      a_neg_q <= sum_neg;
      fit_q   <= sum_fit;
    end
    if (res_start) begin
      out_status_q <= st_d;
      out_num_q    <= num_d;
      out_den_q    <= den_d;
      out_order_q  <= ord_d;
    end
  end

  assign stat_o.eng_done = edone_q;
  assign stat_o.out_busy = out_valid_q;
  assign stat_o.a_inv    = a_inv_q;
  assign stat_o.b_inv    = b_inv_q;
  assign stat_o.fit      = fit_q;
  assign stat_o.action   = act_q;

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign res_num_o   = out_num_q;
  assign res_den_o   = out_den_q;
  assign order_o     = out_order_q;

  // ---- assertions ----
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eng_start |-> !ebusy_q)
    else $error("engine started while busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    edone_q |-> !ebusy_q)
    else $error("engine done while still busy");

  a_result_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_start |-> !out_valid_q)
    else $error("result written over a pending transaction");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q != ST_OK)) |->
      ((out_num_q == '0) && (out_den_q == '0) && (out_order_q == OrdEq)))
    else $error("failed transaction carries nonzero payload");

endmodule

`default_nettype wire
